// ===== rtl/mtne_pkg.sv =====
// Package for the MIDI track note extractor: request/result types, codes, drum map.
package mtne_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
        logic       file_start;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [31:0] event_tick;
        logic [3:0]  track_index;
        logic [23:0] tempo_value;
    } t_out_res;

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_TEMPO = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [3:0] EV_NOTE_ON  = 4'h9;
    localparam logic [3:0] EV_NOTE_OFF = 4'h8;
    localparam logic [3:0] EV_POLY_AT  = 4'hA;
    localparam logic [3:0] EV_CTRL     = 4'hB;
    localparam logic [3:0] EV_BEND     = 4'hE;
    localparam logic [3:0] DRUM_CH     = 4'd9;
    localparam logic [4:0] CH_SEL_RST  = 5'd9;

    typedef enum logic [9:0] {
        PH_DELTA     = 10'b0000000001,
        PH_STATUS    = 10'b0000000010,
        PH_DATA1     = 10'b0000000100,
        PH_VEL       = 10'b0000001000,
        PH_SKIP1     = 10'b0000010000,
        PH_META_TYPE = 10'b0000100000,
        PH_META_LEN  = 10'b0001000000,
        PH_TEMPO     = 10'b0010000000,
        PH_SYSEX_LEN = 10'b0100000000,
        PH_SKIP      = 10'b1000000000
    } t_phase;

    // GM drum map: returns {hit, track}.
    function automatic logic [4:0] drum_lookup(input logic [7:0] note);
        logic [4:0] res;
        res = 5'd0;
        unique case (note)
            8'd35: res = {1'b1, 4'd0};
            8'd36: res = {1'b1, 4'd0};
            8'd37: res = {1'b1, 4'd12};
            8'd38: res = {1'b1, 4'd1};
            8'd39: res = {1'b1, 4'd13};
            8'd40: res = {1'b1, 4'd1};
            8'd41: res = {1'b1, 4'd6};
            8'd42: res = {1'b1, 4'd2};
            8'd43: res = {1'b1, 4'd7};
            8'd44: res = {1'b1, 4'd3};
            8'd45: res = {1'b1, 4'd8};
            8'd46: res = {1'b1, 4'd4};
            8'd47: res = {1'b1, 4'd9};
            8'd48: res = {1'b1, 4'd10};
            8'd49: res = {1'b1, 4'd5};
            8'd50: res = {1'b1, 4'd11};
            8'd51: res = {1'b1, 4'd14};
            8'd52: res = {1'b1, 4'd5};
            8'd53: res = {1'b1, 4'd14};
            8'd54: res = {1'b1, 4'd15};
            8'd55: res = {1'b1, 4'd5};
            8'd56: res = {1'b1, 4'd15};
            8'd57: res = {1'b1, 4'd5};
            8'd59: res = {1'b1, 4'd14};
            default: begin
                if (note >= 8'd60 && note <= 8'd81) res = {1'b1, 4'd15};
                else res = 5'd0;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/midi_track_note_extractor.sv =====
// MIDI track note extractor: top level with input register, parser and result register.
// Usage:
//   Request channel: i_in_valid / o_in_stall carry one track body byte per request
//   with track_start and file_start flags. A request is taken on an edge with
//   valid high and stall low.
//   Result channel: o_out_valid / i_out_stall carry note, tempo and error results.
//   Config: i_cfg_we writes i_cfg_data into channel_select; write only when idle.
//   Flow: a taken request is held in the input register, then parsed into the result
//   register when that register is empty or its result is being taken.
//   Throughput: one byte per cycle while the receiver does not stall; the parse state is one register step per byte.
//   Requests causing no result only update parse state.
//   Reset: synchronous, active low; clears parse state, channel_select to 9,
//   both valids low.
//   When the receiver stalls, the result is held and one more request can sit
//   in the input register; after that o_in_stall goes high.
module midi_track_note_extractor
    import mtne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_req    i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_res   o_out_res,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    logic        r_in_vld;
    t_in_req     r_in;
    logic        r_out_vld;
    t_out_res    r_out;
    logic [4:0]  r_ch_sel;

    t_phase      r_phase,      n_phase;
    logic [27:0] r_len_acc,    n_len_acc;
    logic [2:0]  r_len_bytes,  n_len_bytes;
    logic [31:0] r_tick,       n_tick;
    logic [7:0]  r_run_st,     n_run_st;
    logic [7:0]  r_meta_kind,  n_meta_kind;
    logic [27:0] r_skip,       n_skip;
    logic [23:0] r_tempo_acc,  n_tempo_acc;
    logic [1:0]  r_tempo_bytes, n_tempo_bytes;
    logic        r_tempo_seen, n_tempo_seen;
    logic [7:0]  r_first,      n_first;
    logic        r_err,        n_err;

    logic        adv;
    logic        emit;
    t_out_res    res;

    logic [7:0]  b;
    logic [27:0] vlq_acc;
    logic [2:0]  vlq_bytes;
    logic [23:0] t_acc;
    logic [1:0]  t_bytes;
    logic [3:0]  ev;
    logic [3:0]  ch;
    logic        all_ch;
    logic [4:0]  drum;

    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

    always_comb begin
        b         = r_in.data_byte;
        n_phase       = r_phase;
        n_len_acc     = r_len_acc;
        n_len_bytes   = r_len_bytes;
        n_tick        = r_tick;
        n_run_st      = r_run_st;
        n_meta_kind   = r_meta_kind;
        n_skip        = r_skip;
        n_tempo_acc   = r_tempo_acc;
        n_tempo_bytes = r_tempo_bytes;
        n_tempo_seen  = r_tempo_seen;
        n_first       = r_first;
        n_err         = r_err;
        emit          = 1'b0;
        res           = '0;

        if (r_in.file_start) begin
            n_tempo_seen = 1'b0;
            n_err        = 1'b0;
        end
        if (r_in.file_start || r_in.track_start) begin
            n_phase       = PH_DELTA;
            n_len_acc     = '0;
            n_len_bytes   = '0;
            n_tick        = '0;
            n_run_st      = '0;
            n_meta_kind   = '0;
            n_skip        = '0;
            n_tempo_acc   = '0;
            n_tempo_bytes = '0;
            n_first       = '0;
        end

        vlq_acc   = {n_len_acc[20:0], b[6:0]};
        vlq_bytes = n_len_bytes + 3'd1;
        t_acc     = {n_tempo_acc[15:0], b};
        t_bytes   = n_tempo_bytes + 2'd1;
        ev        = n_run_st[7:4];
        ch        = n_run_st[3:0];
        all_ch    = r_ch_sel[4];
        drum      = drum_lookup(n_first);

        if (!n_err) begin
            unique case (n_phase)
                PH_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
                    n_len_acc   = vlq_acc;
                    n_len_bytes = vlq_bytes;
                    if (b[7] && vlq_bytes >= 3'd4) begin
                        n_err        = 1'b1;
                        emit         = 1'b1;
                        res.out_kind = KIND_ERROR;
                    end else if (!b[7]) begin
                        n_len_acc   = '0;
                        n_len_bytes = '0;
                        if (n_phase == PH_DELTA) begin
                            n_tick  = n_tick + {4'd0, vlq_acc};
                            n_phase = PH_STATUS;
                        end else if (n_phase == PH_META_LEN && n_meta_kind == META_TEMPO
                                     && vlq_acc == 28'd3 && !n_tempo_seen) begin
                            n_tempo_acc   = '0;
                            n_tempo_bytes = '0;
                            n_phase       = PH_TEMPO;
                        end else begin
                            n_skip  = vlq_acc;
                            n_phase = (vlq_acc == 28'd0) ? PH_DELTA : PH_SKIP;
                        end
                    end
                end
                PH_STATUS, PH_DATA1: begin
                    if (n_phase == PH_STATUS && b == ST_META) begin
                        n_phase = PH_META_TYPE;
                    end else if (n_phase == PH_STATUS && (b == ST_SYSEX || b == ST_SYSEX_CT))
                    begin
                        n_phase = PH_SYSEX_LEN;
                    end else if (n_phase == PH_STATUS && b[7]) begin
                        n_run_st = b;
                        n_phase  = PH_DATA1;
                    end else begin
                        n_first = b;
                        if (ev == EV_NOTE_ON || ev == EV_NOTE_OFF) n_phase = PH_VEL;
                        else if (ev == EV_POLY_AT || ev == EV_CTRL || ev == EV_BEND)
                            n_phase = PH_SKIP1;
                        else n_phase = PH_DELTA;
                    end
                end
                PH_VEL: begin
                    n_phase = PH_DELTA;
                    if (ev == EV_NOTE_ON && b != 8'd0) begin
                        res.event_tick = n_tick;
                        if (ch == DRUM_CH) begin
                            if ((all_ch || r_ch_sel == CH_SEL_RST) && drum[4]) begin
                                emit            = 1'b1;
                                res.track_index = drum[3:0];
                            end
                        end else if (all_ch || r_ch_sel == {1'b0, ch}) begin
                            emit            = 1'b1;
                            res.track_index = n_first[3:0];
                        end
                    end
                end
                PH_SKIP1: n_phase = PH_DELTA;
                PH_META_TYPE: begin
                    n_meta_kind = b;
                    n_phase     = PH_META_LEN;
                end
                PH_TEMPO: begin
                    n_tempo_acc   = t_acc;
                    n_tempo_bytes = t_bytes;
                    if (t_bytes == 2'd3) begin
                        n_phase       = PH_DELTA;
                        n_tempo_acc   = '0;
                        n_tempo_bytes = '0;
                        if (t_acc != 24'd0) begin
                            n_tempo_seen    = 1'b1;
                            emit            = 1'b1;
                            res.out_kind    = KIND_TEMPO;
                            res.tempo_value = t_acc;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = n_skip - 28'd1;
                    if (n_skip == 28'd0) n_phase = PH_DELTA;
                end
                default: n_phase = PH_DELTA;
            endcase
        end
        if (!emit) res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_ch_sel      <= CH_SEL_RST;
            r_phase       <= PH_DELTA;
            r_len_acc     <= '0;
            r_len_bytes   <= '0;
            r_tick        <= '0;
            r_run_st      <= '0;
            r_meta_kind   <= '0;
            r_skip        <= '0;
            r_tempo_acc   <= '0;
            r_tempo_bytes <= '0;
            r_tempo_seen  <= 1'b0;
            r_first       <= '0;
            r_err         <= 1'b0;
        end else begin
            if (i_cfg_we) r_ch_sel <= i_cfg_data;
            if (!o_in_stall) r_in_vld <= i_in_valid;
            if (adv) begin
                r_out_vld     <= emit;
                r_phase       <= n_phase;
                r_len_acc     <= n_len_acc;
                r_len_bytes   <= n_len_bytes;
                r_tick        <= n_tick;
                r_run_st      <= n_run_st;
                r_meta_kind   <= n_meta_kind;
                r_skip        <= n_skip;
                r_tempo_acc   <= n_tempo_acc;
                r_tempo_bytes <= n_tempo_bytes;
                r_tempo_seen  <= n_tempo_seen;
                r_first       <= n_first;
                r_err         <= n_err;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) r_in <= i_in_req;
        if (adv && emit) r_out <= res;
    end

endmodule

// ===== rtl/mtne_checker.sv =====
// Port-level checker for the MIDI track note extractor, with its bind.
module mtne_checker
    import mtne_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out_res
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.out_kind == KIND_NOTE ||
                         o_out_res.out_kind == KIND_TEMPO ||
                         o_out_res.out_kind == KIND_ERROR))
        else $error("bad result kind");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.out_kind != KIND_NOTE |->
            o_out_res.event_tick == 32'd0 && o_out_res.track_index == 4'd0)
        else $error("note fields set on non-note result");

endmodule

bind midi_track_note_extractor mtne_checker u_mtne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);
